[hw/rtl/gn2d_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn2d_pkg: shared types, constants and functions of the gradient noise block
// Request formats, hash constants, pipeline depths and the hash round.
// ---------------------------------------------------------------------------
package gn2d_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int OUT_FRAC_BITS_DEF = 15;

    localparam logic [31:0] MIX_K0   = 32'h479a_b41d;
    localparam logic [31:0] MIX_K1   = 32'he4aa_10ce;
    localparam logic [31:0] MIX_K2   = 32'h9942_f0a6;
    localparam logic [31:0] MIX_K3   = 32'h5aed_d67d;
    localparam logic [31:0] MIX_K4   = 32'h17be_a992;
    localparam logic [31:0] MIX_SALT = 32'h1111_1111;
    localparam logic [15:0] CELL_BIAS = 16'h8000;
    localparam logic [15:0] GRAD_MAX  = 16'((1 << 15) - 1);

    localparam int HASH_ROUNDS = 5;
    localparam int ROOT_BITS   = 32;
    localparam int QUOT_BITS   = 16;
    localparam int DIV_W       = ROOT_BITS + QUOT_BITS;

    // hash, magnitude, maximum, two normalise, square, sum, root, numerator,
    // divide, output
    localparam int GRAD_LAT = HASH_ROUNDS + 1 + 1 + 2 + 1 + 1 + ROOT_BITS + 1
                              + QUOT_BITS + 1;
    localparam int FADE_LAT = 5;
    localparam int POST_LAT = 9;
    localparam int PIPE_LAT = 1 + GRAD_LAT + POST_LAT;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] noise_value;
    } t_out_rsp;

    typedef struct packed {
        logic signed [31:0] seed;
    } t_cfg_req;

    // One round of the five-round integer hash.
    function automatic logic [31:0] mix_round(input logic [31:0] a, input logic [2:0] rnd);
        logic [31:0] r;
        case (rnd)
            3'd0:    r = (a + MIX_K0) + (a << 8);
            3'd1:    r = (a ^ MIX_K1) ^ (a >> 5);
            3'd2:    r = (a + MIX_K2) - (a << 14);
            3'd3:    r = (a ^ MIX_K3) ^ (a >> 3);
            3'd4:    r = (a + MIX_K4) + (a << 7);
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/gn2d_stream_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn2d_stream_if: valid/ready channel
// Carries one request per accepted handshake, payload type set per instance.
// ---------------------------------------------------------------------------
interface gn2d_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/gn2d_delay.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn2d_delay: enabled delay line
// Carries side data alongside a pipeline, advancing with the pipeline enable.
// ---------------------------------------------------------------------------
module gn2d_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];
endmodule

[hw/rtl/gn2d_grad.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn2d_grad: corner gradient pipeline
// Hashes one biased cell coordinate into a unit gradient in Q1.15 through
// hash rounds, normalising shift, square root and two long divisions.
// ---------------------------------------------------------------------------
module gn2d_grad (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_cell,
    input  logic [31:0]        i_hs,
    output logic signed [15:0] o_gx,
    output logic signed [15:0] o_gy
);
    localparam int RB = gn2d_pkg::ROOT_BITS;
    localparam int QB = gn2d_pkg::QUOT_BITS;
    localparam int DW = gn2d_pkg::DIV_W;
    localparam int HR = gn2d_pkg::HASH_ROUNDS;

    typedef struct packed {
        logic neg1;
        logic neg2;
        logic zero;
    } t_side;

    // Hash rounds
    logic [31:0] r_h1 [HR];
    logic [31:0] r_h2 [HR];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h1[0] <= gn2d_pkg::mix_round(i_cell ^ i_hs, 3'd0);
            r_h2[0] <= gn2d_pkg::mix_round(i_cell ^ i_hs ^ gn2d_pkg::MIX_SALT, 3'd0);
            for (int k = 1; k < HR; k++) begin
                r_h1[k] <= gn2d_pkg::mix_round(r_h1[k-1], 3'(k));
                r_h2[k] <= gn2d_pkg::mix_round(r_h2[k-1], 3'(k));
            end
        end
    end

    // Magnitudes, larger magnitude, then the normalising shift in two stages
    logic [31:0] r_m1, r_m2;
    t_side       r_msd;
    logic [31:0] r_x_m1, r_x_m2, r_x_w;
    t_side       r_xsd;
    logic [31:0] r_na_m1, r_na_m2, r_na_w;
    t_side       r_nasd;
    logic [31:0] r_nb_m1, r_nb_m2;
    t_side       r_nbsd;
    logic [31:0] w_a1, w_a2, w_aw, w_b1, w_b2, w_bw;

    always_comb begin
        w_aw = r_x_w;
        w_a1 = r_x_m1;
        w_a2 = r_x_m2;
        if (w_aw < 32'h0000_8000) begin
            w_aw = w_aw << 16;
            w_a1 = w_a1 << 16;
            w_a2 = w_a2 << 16;
        end
        if (w_aw < 32'h0080_0000) begin
            w_aw = w_aw << 8;
            w_a1 = w_a1 << 8;
            w_a2 = w_a2 << 8;
        end
        if (w_aw < 32'h0800_0000) begin
            w_aw = w_aw << 4;
            w_a1 = w_a1 << 4;
            w_a2 = w_a2 << 4;
        end
    end

    always_comb begin
        w_bw = r_na_w;
        w_b1 = r_na_m1;
        w_b2 = r_na_m2;
        if (w_bw < 32'h2000_0000) begin
            w_bw = w_bw << 2;
            w_b1 = w_b1 << 2;
            w_b2 = w_b2 << 2;
        end
        if (w_bw < 32'h4000_0000) begin
            w_b1 = w_b1 << 1;
            w_b2 = w_b2 << 1;
        end
    end

    logic [2*RB-1:0] r_sq1, r_sq2, r_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1       <= r_h1[HR-1][31] ? (32'd0 - r_h1[HR-1]) : r_h1[HR-1];
            r_m2       <= r_h2[HR-1][31] ? (32'd0 - r_h2[HR-1]) : r_h2[HR-1];
            r_msd.neg1 <= r_h1[HR-1][31];
            r_msd.neg2 <= r_h2[HR-1][31];
            r_msd.zero <= (r_h1[HR-1] == 32'd0) && (r_h2[HR-1] == 32'd0);
            r_x_m1     <= r_m1;
            r_x_m2     <= r_m2;
            r_x_w      <= (r_m1 > r_m2) ? r_m1 : r_m2;
            r_xsd      <= r_msd;
            r_na_m1    <= w_a1;
            r_na_m2    <= w_a2;
            r_na_w     <= w_aw;
            r_nasd     <= r_xsd;
            r_nb_m1    <= w_b1;
            r_nb_m2    <= w_b2;
            r_nbsd     <= r_nasd;
            r_sq1      <= r_nb_m1 * r_nb_m1;
            r_sq2      <= r_nb_m2 * r_nb_m2;
            r_v        <= r_sq1 + r_sq2;
        end
    end

    // Normalised magnitudes wait beside the square and root stages
    logic [31:0] w_dm1, w_dm2;
    t_side       w_dsd;

    gn2d_delay #(
        .W     (32 + 32 + $bits(t_side)),
        .DEPTH (2 + RB)
    ) u_mag_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_nb_m1, r_nb_m2, r_nbsd}),
        .o_q   ({w_dm1, w_dm2, w_dsd})
    );

    // Square root, one result bit per stage
    logic [2*RB-1:0] r_rem [RB];
    logic [RB-1:0]   r_q   [RB];

    for (genvar j = 0; j < RB; j++) begin : g_root
        localparam int I = RB - 1 - j;
        logic [2*RB-1:0] w_rin, w_trial;
        logic [RB-1:0]   w_qin;
        if (j == 0) begin : g_first
            assign w_rin = r_v;
            assign w_qin = '0;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_qin = r_q[j-1];
        end
        assign w_trial = ((2*RB)'(w_qin) << (I + 1)) + ((2*RB)'(1) << (2 * I));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rin >= w_trial) begin
                    r_rem[j] <= w_rin - w_trial;
                    r_q[j]   <= w_qin | (RB'(1) << I);
                end else begin
                    r_rem[j] <= w_rin;
                    r_q[j]   <= w_qin;
                end
            end
        end
    end

    // Numerators m * 2^15 + s / 2 for the rounded division
    logic [DW-1:0] r_n1, r_n2;
    logic [RB-1:0] r_s;
    t_side         r_nsd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1  <= (DW'(w_dm1) << (QB - 1)) + DW'(r_q[RB-1] >> 1);
            r_n2  <= (DW'(w_dm2) << (QB - 1)) + DW'(r_q[RB-1] >> 1);
            r_s   <= r_q[RB-1];
            r_nsd <= w_dsd;
        end
    end

    // Long division, one quotient bit per stage, both components side by side
    logic [DW-1:0] r_r1 [QB];
    logic [DW-1:0] r_r2 [QB];
    logic [QB-1:0] r_c1 [QB];
    logic [QB-1:0] r_c2 [QB];
    logic [RB-1:0] r_ds [QB];
    t_side         r_dsd [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int I = QB - 1 - j;
        logic [DW-1:0] w_r1, w_r2, w_d;
        logic [QB-1:0] w_c1, w_c2;
        logic [RB-1:0] w_s;
        t_side         w_sd;
        if (j == 0) begin : g_first
            assign w_r1 = r_n1;
            assign w_r2 = r_n2;
            assign w_c1 = '0;
            assign w_c2 = '0;
            assign w_s  = r_s;
            assign w_sd = r_nsd;
        end else begin : g_next
            assign w_r1 = r_r1[j-1];
            assign w_r2 = r_r2[j-1];
            assign w_c1 = r_c1[j-1];
            assign w_c2 = r_c2[j-1];
            assign w_s  = r_ds[j-1];
            assign w_sd = r_dsd[j-1];
        end
        assign w_d = DW'(w_s) << I;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_r1 >= w_d) begin
                    r_r1[j] <= w_r1 - w_d;
                    r_c1[j] <= w_c1 | (QB'(1) << I);
                end else begin
                    r_r1[j] <= w_r1;
                    r_c1[j] <= w_c1;
                end
                if (w_r2 >= w_d) begin
                    r_r2[j] <= w_r2 - w_d;
                    r_c2[j] <= w_c2 | (QB'(1) << I);
                end else begin
                    r_r2[j] <= w_r2;
                    r_c2[j] <= w_c2;
                end
                r_ds[j]  <= w_s;
                r_dsd[j] <= w_sd;
            end
        end
    end

    // Saturate a full-scale component, apply the sign, zero a zero hash pair
    logic signed [15:0] w_g1, w_g2, r_gx, r_gy;
    t_side              w_osd;

    assign w_osd = r_dsd[QB-1];
    assign w_g1  = (r_c1[QB-1] > gn2d_pkg::GRAD_MAX) ? gn2d_pkg::GRAD_MAX : r_c1[QB-1];
    assign w_g2  = (r_c2[QB-1] > gn2d_pkg::GRAD_MAX) ? gn2d_pkg::GRAD_MAX : r_c2[QB-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx <= w_osd.zero ? 16'sd0 : (w_osd.neg1 ? -w_g1 : w_g1);
            r_gy <= w_osd.zero ? 16'sd0 : (w_osd.neg2 ? -w_g2 : w_g2);
        end
    end

    assign o_gx = r_gx;
    assign o_gy = r_gy;
endmodule

[hw/rtl/gradient_noise_2d.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gradient_noise_2d: 2D gradient noise, one sample per cycle unless stalled
// Sample point in signed fixed point in, interpolated noise in Q1.15 out.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Payload                          Request
//   i_cfg    in         seed (32 bit signed)             seed write
//   i_in     in         x_coord, y_coord (32 bit signed) one sample point
//   o_out    out        noise_value (16 bit signed)      one noise value
//
// A new sample is taken in every clock cycle unless the output buffer is full
// or the seed hash is being worked out. The pipeline depth is set by the
// 32-step square root and the 16-step divider in each corner gradient unit.
// After reset and after each seed write the input is not ready while the seed
// hash is worked out one round per cycle. The whole pipeline advances under
// one enable; it halts only when both entries of the output buffer are full,
// so nothing is lost or repeated.
//
module gradient_noise_2d #(
    parameter int FRAC_BITS     = gn2d_pkg::FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = gn2d_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gn2d_stream_if.sink    i_cfg,
    gn2d_stream_if.sink    i_in,
    gn2d_stream_if.source  o_out
);
    localparam int LAT = gn2d_pkg::PIPE_LAT;
    localparam int GL  = gn2d_pkg::GRAD_LAT;
    localparam int SH  = 31 - OUT_FRAC_BITS;

    // Seed hash: one round per cycle after a write, input held off meanwhile.
    logic [31:0] r_hs;
    logic [2:0]  r_hs_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs     <= '0;
            r_hs_cnt <= 3'(gn2d_pkg::HASH_ROUNDS);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_hs     <= i_cfg.payload.seed;
            r_hs_cnt <= 3'(gn2d_pkg::HASH_ROUNDS);
        end else if (r_hs_cnt != 3'd0) begin
            r_hs     <= gn2d_pkg::mix_round(r_hs, 3'(gn2d_pkg::HASH_ROUNDS) - r_hs_cnt);
            r_hs_cnt <= r_hs_cnt - 3'd1;
        end
    end

    assign i_cfg.ready = 1'b1;

    // Pipeline enable comes from the output buffer alone: it advances while
    // the buffer has a free entry.
    logic [1:0]          r_cnt;
    logic                w_en, w_in_acc, w_push, w_pop;
    logic [LAT-1:0]      r_vld;
    gn2d_pkg::t_in_req   r_in;

    assign w_en      = (r_cnt != 2'd2);
    assign i_in.ready = w_en && (r_hs_cnt == 3'd0);
    assign w_in_acc  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_in.payload;
        end
    end

    // Cell indices and fractions of the sample held in r_in.
    logic [15:0] w_cx, w_cy, w_cx1, w_cy1;
    logic [15:0] w_t [2];
    logic [31:0] w_cell [4];

    assign w_cx   = r_in.x_coord[FRAC_BITS +: 16];
    assign w_cy   = r_in.y_coord[FRAC_BITS +: 16];
    assign w_cx1  = w_cx + 16'd1;
    assign w_cy1  = w_cy + 16'd1;
    assign w_t[0] = 16'(r_in.x_coord[FRAC_BITS-1:0]) << (16 - FRAC_BITS);
    assign w_t[1] = 16'(r_in.y_coord[FRAC_BITS-1:0]) << (16 - FRAC_BITS);

    // Corners in the order bottom-left, bottom-right, top-left, top-right,
    // each coordinate biased by half the 16-bit range.
    assign w_cell[0] = {w_cx  ^ gn2d_pkg::CELL_BIAS, w_cy  ^ gn2d_pkg::CELL_BIAS};
    assign w_cell[1] = {w_cx1 ^ gn2d_pkg::CELL_BIAS, w_cy  ^ gn2d_pkg::CELL_BIAS};
    assign w_cell[2] = {w_cx  ^ gn2d_pkg::CELL_BIAS, w_cy1 ^ gn2d_pkg::CELL_BIAS};
    assign w_cell[3] = {w_cx1 ^ gn2d_pkg::CELL_BIAS, w_cy1 ^ gn2d_pkg::CELL_BIAS};

    logic signed [15:0] w_gx [4];
    logic signed [15:0] w_gy [4];

    for (genvar k = 0; k < 4; k++) begin : g_corner
        gn2d_grad u_grad (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cell (w_cell[k]),
            .i_hs   (r_hs),
            .o_gx   (w_gx[k]),
            .o_gy   (w_gy[k])
        );
    end

    // Quintic fade for both axes, truncated to Q4.16 after each step.
    logic [15:0] r_t1 [2];
    logic [15:0] r_t2 [2];
    logic [15:0] r_t3 [2];
    logic [15:0] r_t4 [2];
    logic [31:0] r_sq [2];
    logic [19:0] r_p  [2];
    logic [19:0] r_f3 [2];
    logic [19:0] r_f4 [2];
    logic [16:0] r_f5 [2];
    logic [36:0] w_p  [2];
    logic [35:0] w_m3 [2];
    logic [35:0] w_m4 [2];
    logic [35:0] w_m5 [2];

    for (genvar l = 0; l < 2; l++) begin : g_fade
        assign w_p[l]  = (37'(r_sq[l]) * 37'd6) + (37'd10 << 32)
                         - ((37'(r_t1[l]) * 37'd15) << 16);
        assign w_m3[l] = r_p[l] * r_t2[l];
        assign w_m4[l] = r_f3[l] * r_t3[l];
        assign w_m5[l] = r_f4[l] * r_t4[l];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_t1[l] <= w_t[l];
                r_sq[l] <= w_t[l] * w_t[l];
                r_t2[l] <= r_t1[l];
                r_p[l]  <= w_p[l][35:16];
                r_t3[l] <= r_t2[l];
                r_f3[l] <= w_m3[l][35:16];
                r_t4[l] <= r_t3[l];
                r_f4[l] <= w_m4[l][35:16];
                r_f5[l] <= (w_m5[l][35:16] > 20'd65536) ? 17'd65536 : w_m5[l][32:16];
            end
        end
    end

    // Fractions and fades wait until the corner gradients are out.
    logic [15:0] w_tx, w_ty;
    logic [16:0] w_fx, w_fy;

    gn2d_delay #(
        .W     (32),
        .DEPTH (GL)
    ) u_frac_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_t[0], w_t[1]}),
        .o_q   ({w_tx, w_ty})
    );

    gn2d_delay #(
        .W     (34),
        .DEPTH (GL - gn2d_pkg::FADE_LAT)
    ) u_fade_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_f5[0], r_f5[1]}),
        .o_q   ({w_fx, w_fy})
    );

    // Corner offsets in Q1.16: t, or t - 1 for the far corner.
    logic signed [17:0] w_dx [4];
    logic signed [17:0] w_dy [4];

    assign w_dx[0] = $signed({2'b00, w_tx});
    assign w_dx[1] = $signed({2'b00, w_tx}) - 18'sd65536;
    assign w_dx[2] = $signed({2'b00, w_tx});
    assign w_dx[3] = $signed({2'b00, w_tx}) - 18'sd65536;
    assign w_dy[0] = $signed({2'b00, w_ty});
    assign w_dy[1] = $signed({2'b00, w_ty});
    assign w_dy[2] = $signed({2'b00, w_ty}) - 18'sd65536;
    assign w_dy[3] = $signed({2'b00, w_ty}) - 18'sd65536;

    // Dot products, then two lerps along x and one along y, then rounding.
    logic signed [33:0] r_px  [4];
    logic signed [33:0] r_py  [4];
    logic signed [33:0] r_dot [4];
    logic [16:0]        r_fx1, r_fy1, r_fx2, r_fy2, r_fx3, r_fy3, r_fy4, r_fy5, r_fy6;
    logic signed [34:0] r_dfb, r_dft, r_dd;
    logic signed [33:0] r_ab, r_at, r_ab2, r_at2, r_db, r_dt, r_a2, r_a3, r_d;
    logic signed [52:0] r_prb, r_prt, r_pr2;
    logic signed [34:0] w_rs;
    logic signed [15:0] r_res;

    assign w_rs = (35'(r_d) + (35'sd1 <<< (30 - OUT_FRAC_BITS))) >>> SH;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_px[k]  <= w_gx[k] * w_dx[k];
                r_py[k]  <= w_gy[k] * w_dy[k];
                r_dot[k] <= r_px[k] + r_py[k];
            end
            r_fx1 <= w_fx;
            r_fy1 <= w_fy;
            r_fx2 <= r_fx1;
            r_fy2 <= r_fy1;
            r_dfb <= 35'(r_dot[1]) - 35'(r_dot[0]);
            r_dft <= 35'(r_dot[3]) - 35'(r_dot[2]);
            r_ab  <= r_dot[0];
            r_at  <= r_dot[2];
            r_fx3 <= r_fx2;
            r_fy3 <= r_fy2;
            r_prb <= r_dfb * $signed({1'b0, r_fx3});
            r_prt <= r_dft * $signed({1'b0, r_fx3});
            r_ab2 <= r_ab;
            r_at2 <= r_at;
            r_fy4 <= r_fy3;
            r_db  <= r_ab2 + 34'(r_prb >>> 16);
            r_dt  <= r_at2 + 34'(r_prt >>> 16);
            r_fy5 <= r_fy4;
            r_dd  <= 35'(r_dt) - 35'(r_db);
            r_a2  <= r_db;
            r_fy6 <= r_fy5;
            r_pr2 <= r_dd * $signed({1'b0, r_fy6});
            r_a3  <= r_a2;
            r_d   <= r_a3 + 34'(r_pr2 >>> 16);
            if (w_rs > 35'sd32767) begin
                r_res <= 16'sd32767;
            end else if (w_rs < -35'sd32768) begin
                r_res <= -16'sd32768;
            end else begin
                r_res <= w_rs[15:0];
            end
        end
    end

    // Two-entry output buffer; its fill alone gates the pipeline.
    gn2d_pkg::t_out_rsp r_buf [2];
    logic               r_wr, r_rd;

    assign w_push = w_en && r_vld[LAT-1];
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], w_in_acc};
            end
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr].noise_value <= r_res;
        end
    end

    assign o_out.valid   = (r_cnt != 2'd0);
    assign o_out.payload = r_buf[r_rd];
endmodule

[hw/rtl/gn2d_chk.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn2d_chk: port checker for the gradient noise block
// Watches the channels over time and flags ordering and stall faults.
// ---------------------------------------------------------------------------
module gn2d_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        i_cfg_ready,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_noise
);
    logic [7:0] r_outst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 8'(i_in_valid && i_in_ready)
                       - 8'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_noise))
        else $error("result changed or vanished while stalled");

    a_seed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_in_ready)
        else $error("sample taken while the seed hash is being recomputed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outst != 8'd0)
        else $error("result offered with no sample outstanding");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= 8'(gn2d_pkg::PIPE_LAT + 2))
        else $error("more samples in flight than the pipeline can hold");
endmodule

bind gradient_noise_2d gn2d_chk u_gn2d_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_noise (o_out.payload.noise_value)
);

[tb/sv/gradient_noise_2d_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gradient_noise_2d_test: self-checking bench for the 2D gradient noise block
// Drives a table of directed sample points and then random ones under several
// seeds, predicts values the table does not give and compares each response.
// ---------------------------------------------------------------------------
module gradient_noise_2d_test;

    localparam int DRAIN_CYCLES = gn2d_pkg::PIPE_LAT + 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gn2d_stream_if #(.T(gn2d_pkg::t_cfg_req)) cfg_ch ();
    gn2d_stream_if #(.T(gn2d_pkg::t_in_req))  sample_ch ();
    gn2d_stream_if #(.T(gn2d_pkg::t_out_rsp)) noise_ch ();

    gradient_noise_2d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (sample_ch.sink),
        .o_out   (noise_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: the seed as the bench believes the block holds it.
    logic [31:0] seed_now = 32'd0;
    logic [15:0] noise_due[$];
    int          mismatches = 0;
    int          samples_sent = 0;
    int          values_seen = 0;
    bit          quiet_tail = 1'b0;
    bit          long_hold = 1'b0;

    function automatic logic [31:0] scramble(input logic [31:0] a);
        a = (a + 32'h479ab41d) + (a << 8);
        a = (a ^ 32'he4aa10ce) ^ (a >> 5);
        a = (a + 32'h9942f0a6) - (a << 14);
        a = (a ^ 32'h5aedd67d) ^ (a >> 3);
        a = (a + 32'h17bea992) + (a << 7);
        return a;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint floor_div_pow2(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint unit_comp(input logic [63:0] m, input bit neg,
                                         input logic [63:0] s);
        logic [63:0] g;
        g = (m * 64'd32768 + s / 2) / s;
        if (g > 64'd32767) g = 64'd32767;
        return neg ? -longint'(g) : longint'(g);
    endfunction

    // Dot product of a corner's gradient with the offset to the sample point.
    function automatic longint corner_dot(input logic [15:0] cx, input logic [15:0] cy,
                                          input longint dx, input longint dy);
        logic [31:0] c;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [63:0] m1;
        logic [63:0] m2;
        logic [63:0] mx;
        logic [63:0] s;
        c  = {cx + gn2d_pkg::CELL_BIAS, cy + gn2d_pkg::CELL_BIAS};
        h1 = scramble(c ^ scramble(seed_now));
        h2 = scramble(c ^ scramble(seed_now) ^ gn2d_pkg::MIX_SALT);
        m1 = h1[31] ? {32'd0, -h1} : {32'd0, h1};
        m2 = h2[31] ? {32'd0, -h2} : {32'd0, h2};
        mx = (m1 > m2) ? m1 : m2;
        if (mx == 0) return 0;
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            m1 = m1 << 1;
            m2 = m2 << 1;
        end
        s = int_sqrt(m1 * m1 + m2 * m2);
        return unit_comp(m1, h1[31], s) * dx + unit_comp(m2, h2[31], s) * dy;
    endfunction

    function automatic longint quintic(input logic [63:0] t);
        logic [63:0] f;
        f = (64'd6 * t * t + (64'd10 << 32) - ((64'd15 * t) << 16)) >> 16;
        f = (f * t) >> 16;
        f = (f * t) >> 16;
        f = (f * t) >> 16;
        if (f > 64'd65536) f = 64'd65536;
        return longint'(f);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint t);
        return a + floor_div_pow2((b - a) * t, 16);
    endfunction

    function automatic logic [15:0] noise_at(input logic [31:0] x, input logic [31:0] y);
        logic [15:0] cx;
        logic [15:0] cy;
        longint tx;
        longint ty;
        longint fx;
        longint fy;
        longint lo;
        longint hi;
        longint r;
        cx = x[31:16];
        cy = y[31:16];
        tx = longint'(x[15:0]);
        ty = longint'(y[15:0]);
        fx = quintic(tx);
        fy = quintic(ty);
        lo = blend(corner_dot(cx, cy, tx, ty), corner_dot(cx + 16'd1, cy, tx - 65536, ty), fx);
        hi = blend(corner_dot(cx, cy + 16'd1, tx, ty - 65536),
                   corner_dot(cx + 16'd1, cy + 16'd1, tx - 65536, ty - 65536), fx);
        r = floor_div_pow2(blend(lo, hi, fy) + (longint'(1) << 15), 16);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Directed sample points. Rows with has_known clear are left to the
    // predictor; known values are those that follow at a glance.
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] known;
        bit          has_known;
    } t_probe;

    t_probe probes[] = '{
        '{32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1},  // corner point: zero offset
        '{32'h1234_0000, 32'h8000_0000, 16'h0000, 1'b1},  // on a lattice point again
        '{32'h7fff_0000, 32'hffff_0000, 16'h0000, 1'b1},
        '{32'h0000_8000, 32'h0000_8000, 16'h0000, 1'b0},
        '{32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 1'b0},  // cell wrap at the top
        '{32'h8000_0000, 32'h7fff_ffff, 16'h0000, 1'b0},
        '{32'hffff_ffff, 32'hffff_ffff, 16'h0000, 1'b0},  // wrap from -1 to 0
        '{32'h8000_0001, 32'h8000_0001, 16'h0000, 1'b0},
        '{32'h0000_0001, 32'h0000_ffff, 16'h0000, 1'b0},
        '{32'h0000_ffff, 32'h0000_0001, 16'h0000, 1'b0},
        '{32'hffff_8000, 32'h0000_4000, 16'h0000, 1'b0},
        '{32'h5555_5555, 32'haaaa_aaaa, 16'h0000, 1'b0},
        '{32'haaaa_aaaa, 32'h5555_5555, 16'h0000, 1'b0},
        '{32'h0001_c000, 32'hfffe_2000, 16'h0000, 1'b0},
        '{32'h7fff_0001, 32'h0000_fffe, 16'h0000, 1'b0},
        '{32'h8000_ffff, 32'hffff_0000, 16'h0000, 1'b0}
    };

    // Output side: random stalls, plus one long hold to back the pipe up.
    initial begin
        int gap;
        noise_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                noise_ch.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 14);
                noise_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                noise_ch.ready = 1'b1;
            end
        end
    end

    // Every handshake on the output is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && noise_ch.valid && noise_ch.ready) begin
            values_seen++;
            if (noise_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected noise value %0d", noise_ch.payload.noise_value);
            end else begin
                logic [15:0] want;
                want = noise_due.pop_front();
                if (noise_ch.payload.noise_value !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise value: expected %0d, got %0d",
                                 $signed(want), noise_ch.payload.noise_value);
                end
            end
        end
    end

    task automatic write_seed(input logic [31:0] s);
        cfg_ch.valid = 1'b1;
        cfg_ch.payload.seed = s;
        do @(posedge i_clk); while (!cfg_ch.ready);
        seed_now = s;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Offers one sample point and records its prediction on acceptance.
    task automatic send_sample(input logic [31:0] x, input logic [31:0] y,
                               input bit has_known, input logic [15:0] known);
        logic [15:0] want;
        if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            sample_ch.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        want = has_known ? known : noise_at(x, y);
        sample_ch.valid = 1'b1;
        sample_ch.payload.x_coord = x;
        sample_ch.payload.y_coord = y;
        do @(posedge i_clk); while (!sample_ch.ready);
        noise_due = {noise_due, want};
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        sample_ch.valid = 1'b0;
        while (noise_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return {16'($urandom_range(0, 3)) - 16'd1, 16'($urandom())};
            2:       return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
            default: return {16'($urandom_range(0, 40)), 16'($urandom())};
        endcase
    endfunction

    logic [31:0] seed_list[] = '{32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000,
                                 32'hffff_ffff, 32'h0000_0000};

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        sample_ch.valid = 1'b0;
        sample_ch.payload = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table under the reset seed.
        foreach (probes[k])
            send_sample(probes[k].x, probes[k].y, probes[k].has_known, probes[k].known);

        // Long output hold while samples keep coming: fills the output buffer.
        long_hold = 1'b1;
        repeat (120) send_sample($urandom(), $urandom(), 1'b0, 16'h0);
        settle();

        // Random samples over several seeds, the extremes among them.
        for (int p = 0; p < 6; p++) begin
            write_seed(p < 5 ? seed_list[p] : $urandom());
            if (p == 5) quiet_tail = 1'b1;
            repeat (220) send_sample(pick_coord(), pick_coord(), 1'b0, 16'h0);
            settle();
        end

        $display("%0d sample points sent and %0d noise values checked over seven seeds,",
                 samples_sent, values_seen);
        $display("with output stalls, a long back-pressure hold and wrapping cells.");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

endmodule
